/* rtl/core/canvas_pixel_store_core_assert.svh */
// Assertion macros shared by the checker of the canvas pixel store.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef CANVAS_PIXEL_STORE_CORE_ASSERT_SVH
`define CANVAS_PIXEL_STORE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cps_pkg.sv */
// Package of the canvas pixel store: sizes, codes and the request and
// response types of the shared remainder unit. Depends on nothing.
`default_nettype none

package cps_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int SIZE_W     = 9;
  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int PIXEL_W    = 3 * COLOR_W;
  localparam int OUT_ADDR_W = 16;
  localparam int LIN_W      = 2 * SIZE_W;
  localparam int STEP_W     = $clog2(COORD_W);
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP   = 2'd2;

  typedef struct packed {
    logic                       start;
    logic signed [COORD_W-1:0]  value;
    logic        [SIZE_W-1:0]   divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } mod_rsp_t;

  // A size of zero counts as one; a size above the maximum counts as the maximum.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v, input int maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (int'(v) > maxv) begin
      r = SIZE_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cps_mod.sv */
// Shared remainder unit: true modulo of a signed coordinate by a size,
// one quotient bit per cycle. Depends on cps_pkg.
`default_nettype none

module cps_mod (
  input  logic              clk,
  input  logic              rst,
  input  cps_pkg::mod_req_t req,
  output cps_pkg::mod_rsp_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;

  state_t                             state;
  logic [cps_pkg::COORD_W-1:0]        mag;
  logic [cps_pkg::SIZE_W-1:0]         rem;
  logic [cps_pkg::SIZE_W-1:0]         div;
  logic                               neg;
  logic [cps_pkg::STEP_W-1:0]         step;
  logic [cps_pkg::SIZE_W:0]           trial;
  logic [cps_pkg::SIZE_W:0]           div_ext;

  assign trial   = {rem, mag[cps_pkg::COORD_W-1]};
  assign div_ext = {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            neg   <= req.value[cps_pkg::COORD_W-1];
            mag   <= req.value[cps_pkg::COORD_W-1] ? $unsigned(-req.value)
                                                   : $unsigned(req.value);
            rem   <= '0;
            div   <= req.divisor;
            step  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (trial >= div_ext) begin
            rem <= cps_pkg::SIZE_W'(trial - div_ext);
          end else begin
            rem <= trial[cps_pkg::SIZE_W-1:0];
          end
          mag  <= mag << 1;
          step <= step + 1'b1;
          if (step == cps_pkg::STEP_W'(cps_pkg::COORD_W - 1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          // A negative value with a nonzero remainder folds back from the size.
          rsp.rem  <= (neg && rem != '0) ? div - rem : rem;
          rsp.done <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/canvas_pixel_store_core.sv */
// Canvas pixel store: RGB framebuffer with signed coordinate addressing.
// Depends on cps_pkg and cps_mod.
//
// A request is taken at a clock edge where start is high and busy is low.
// Mode write places a color, mode read returns the stored color and mode
// fill stores one color in every entry of the configured canvas. Each
// request gives one result, shown for one cycle with done high; the
// receiver cannot stall it. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while busy is low,
// which the block itself does not enforce. A read passes through the
// coordinate, multiply, access and read data states, a clamped write
// through the coordinate, flip, multiply and access states; a wrapped
// write first passes both coordinates in turn through one remainder unit
// that retires one bit per cycle, and a fill writes one entry per cycle
// through the single memory port. An unknown mode answers with zeros; busy
// stays high until the done cycle. Reset returns the sequencer to idle
// and the sizes to their maximum with clamping; canvas memory is not cleared.
`default_nettype none

module canvas_pixel_store_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [cps_pkg::MODE_W-1:0]          mode,
  input  logic signed [cps_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [cps_pkg::COORD_W-1:0]  y_coord,
  input  logic [cps_pkg::COLOR_W-1:0]         red_in,
  input  logic [cps_pkg::COLOR_W-1:0]         green_in,
  input  logic [cps_pkg::COLOR_W-1:0]         blue_in,
  output logic                                done,
  output logic [cps_pkg::OUT_ADDR_W-1:0]      pixel_address,
  output logic [cps_pkg::COLOR_W-1:0]         red_out,
  output logic [cps_pkg::COLOR_W-1:0]         green_out,
  output logic [cps_pkg::COLOR_W-1:0]         blue_out,
  input  logic                                cfg_we,
  input  logic [cps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cps_pkg::SIZE_W-1:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_COORD, S_MOD_X, S_MOD_Y, S_FLIP, S_MUL, S_ACCESS, S_RDATA,
    S_FILL_SIZE, S_FILL
  } state_t;

  state_t                             state;
  logic [cps_pkg::SIZE_W-1:0]         canvas_width;
  logic [cps_pkg::SIZE_W-1:0]         canvas_height;
  logic                               wrap_enable;

  logic [cps_pkg::MODE_W-1:0]         mode_reg;
  logic signed [cps_pkg::COORD_W-1:0] x_reg;
  logic signed [cps_pkg::COORD_W-1:0] y_reg;
  logic [cps_pkg::PIXEL_W-1:0]        color;
  logic [cps_pkg::SIZE_W-1:0]         w_size;
  logic [cps_pkg::SIZE_W-1:0]         h_size;
  logic [cps_pkg::SIZE_W-1:0]         cx;
  logic [cps_pkg::SIZE_W-1:0]         cy;
  logic [cps_pkg::SIZE_W-1:0]         cx_clamp;
  logic [cps_pkg::SIZE_W-1:0]         cy_clamp;
  logic [cps_pkg::ADDR_W-1:0]         lin;
  logic [cps_pkg::ADDR_W-1:0]         fill_idx;
  logic [cps_pkg::ADDR_W-1:0]         fill_last;

  logic [cps_pkg::PIXEL_W-1:0]        mem [cps_pkg::DEPTH];
  logic [cps_pkg::PIXEL_W-1:0]        rdata;
  logic [cps_pkg::ADDR_W-1:0]         mem_addr;
  logic                               mem_we;

  cps_pkg::mod_req_t                  mod_req;
  cps_pkg::mod_rsp_t                  mod_rsp;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= cps_pkg::SIZE_W'(256);
      canvas_height <= cps_pkg::SIZE_W'(256);
      wrap_enable   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cps_pkg::REG_WIDTH:  canvas_width  <= cfg_data;
        cps_pkg::REG_HEIGHT: canvas_height <= cfg_data;
        cps_pkg::REG_WRAP:   wrap_enable   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (x_reg[cps_pkg::COORD_W-1]) begin
      cx_clamp = '0;
    end else if ($unsigned(x_reg) >= cps_pkg::COORD_W'(w_size)) begin
      cx_clamp = w_size - cps_pkg::SIZE_W'(1);
    end else begin
      cx_clamp = cps_pkg::SIZE_W'(x_reg);
    end
    if (y_reg[cps_pkg::COORD_W-1]) begin
      cy_clamp = '0;
    end else if ($unsigned(y_reg) >= cps_pkg::COORD_W'(h_size)) begin
      cy_clamp = h_size - cps_pkg::SIZE_W'(1);
    end else begin
      cy_clamp = cps_pkg::SIZE_W'(y_reg);
    end
  end

  always_comb begin
    mod_req.start   = (state == S_COORD && mode_reg == cps_pkg::MODE_WRITE && wrap_enable)
                      || (state == S_MOD_X && mod_rsp.done);
    mod_req.value   = (state == S_COORD) ? x_reg : y_reg;
    mod_req.divisor = (state == S_COORD) ? w_size : h_size;
  end

  cps_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  assign mem_we   = (state == S_FILL)
                    || (state == S_ACCESS && mode_reg == cps_pkg::MODE_WRITE);
  assign mem_addr = (state == S_FILL) ? fill_idx : lin;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= color;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            mode_reg <= mode;
            x_reg    <= x_coord;
            y_reg    <= y_coord;
            color    <= {blue_in, green_in, red_in};
            w_size   <= cps_pkg::eff_size(canvas_width, cps_pkg::MAX_WIDTH);
            h_size   <= cps_pkg::eff_size(canvas_height, cps_pkg::MAX_HEIGHT);
            state    <= S_COORD;
          end
        end
        S_COORD: begin
          cx <= cx_clamp;
          cy <= cy_clamp;
          case (mode_reg)
            cps_pkg::MODE_WRITE: state <= wrap_enable ? S_MOD_X : S_FLIP;
            cps_pkg::MODE_READ:  state <= S_MUL;
            cps_pkg::MODE_FILL:  state <= S_FILL_SIZE;
            default: begin
              pixel_address <= '0;
              red_out       <= '0;
              green_out     <= '0;
              blue_out      <= '0;
              done          <= 1'b1;
              state         <= S_IDLE;
            end
          endcase
        end
        S_MOD_X: begin
          if (mod_rsp.done) begin
            cx    <= mod_rsp.rem;
            state <= S_MOD_Y;
          end
        end
        S_MOD_Y: begin
          if (mod_rsp.done) begin
            cy    <= mod_rsp.rem;
            state <= S_FLIP;
          end
        end
        S_FLIP: begin
          cy    <= h_size - cps_pkg::SIZE_W'(1) - cy;
          state <= S_MUL;
        end
        S_MUL: begin
          lin   <= cps_pkg::ADDR_W'(cps_pkg::LIN_W'(w_size) * cps_pkg::LIN_W'(cy)
                   + cps_pkg::LIN_W'(cx));
          state <= S_ACCESS;
        end
        S_ACCESS: begin
          if (mode_reg == cps_pkg::MODE_WRITE) begin
            pixel_address <= cps_pkg::OUT_ADDR_W'(lin);
            {blue_out, green_out, red_out} <= color;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_RDATA;
          end
        end
        S_RDATA: begin
          pixel_address <= cps_pkg::OUT_ADDR_W'(lin);
          {blue_out, green_out, red_out} <= rdata;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        S_FILL_SIZE: begin
          fill_idx  <= '0;
          fill_last <= cps_pkg::ADDR_W'(cps_pkg::LIN_W'(w_size) * cps_pkg::LIN_W'(h_size)
                       - cps_pkg::LIN_W'(1));
          state     <= S_FILL;
        end
        S_FILL: begin
          fill_idx <= fill_idx + 1'b1;
          if (fill_idx == fill_last) begin
            pixel_address <= '0;
            {blue_out, green_out, red_out} <= color;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cps_chk.sv */
// Port level checker of the canvas pixel store and its bind to the top level.
// Depends on canvas_pixel_store_core_assert.svh.
`default_nettype none

`include "canvas_pixel_store_core_assert.svh"

module cps_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `CPS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted request did not raise busy")
  `CPS_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result shown while busy")
  `CPS_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe longer than one cycle")
  `CPS_ASSERT_SAME(a_busy_end, clk, rst, !$past(rst) && $fell(busy), done, "busy ended without a result")

endmodule

bind canvas_pixel_store_core cps_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire
